// ----- rtl/core/clbw_pkg.sv -----
// ----------------------------------------------------------------------------
// clbw_pkg
// Shared types, codes and command tables for the character LCD backpack writer.
// ----------------------------------------------------------------------------
package clbw_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RS_MASK        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_BASE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_BASE      = 3'd4;

  // Request kinds
  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_CLEAR  = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_CHAR   = 3'd3;
  localparam logic [2:0] REQ_INT    = 3'd4;

  // Display commands and characters
  localparam logic [7:0] LCD_CMD_CLEAR = 8'h01;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_MINUS      = 8'h2D;

  // Settle waits
  localparam logic [12:0] WAIT_STROBE_HI = 13'd1;
  localparam logic [12:0] WAIT_STROBE_LO = 13'd50;

  // Op queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Extra wait added to the strobe-low write of an op's final nibble
  typedef enum logic [2:0] {
    EXT_NONE,
    EXT_1000,
    EXT_2000,
    EXT_4000,
    EXT_5000
  } clbw_ext_t;

  // One queued op: a full byte (two nibbles) or a single high nibble
  typedef struct packed {
    logic [7:0] code;
    logic       data;
    logic       nib_only;
    clbw_ext_t  ext;
    logic       last;
  } clbw_op_t;

  typedef struct packed {
    logic [7:0] rs_mask;
    logic [7:0] enable_mask;
    logic [7:0] backlight_mask;
  } clbw_masks_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } clbw_qstat_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CMD,
    F_SIGN,
    F_CONV,
    F_DIGIT
  } clbw_fstate_t;

  function automatic logic [12:0] ext_us(clbw_ext_t e);
    logic [12:0] v;
    unique case (e)
      EXT_1000: v = 13'd1000;
      EXT_2000: v = 13'd2000;
      EXT_4000: v = 13'd4000;
      EXT_5000: v = 13'd5000;
      default:  v = 13'd0;
    endcase
    return v;
  endfunction

  // Power-up sequence: three 8-bit-mode nibbles, switch to 4-bit, then setup
  function automatic clbw_op_t init_op(logic [2:0] idx);
    clbw_op_t op;
    op.data     = 1'b0;
    op.nib_only = 1'b0;
    op.last     = 1'b0;
    unique case (idx)
      3'd0: begin op.code = 8'h30; op.nib_only = 1'b1; op.ext = EXT_5000; end
      3'd1: begin op.code = 8'h30; op.nib_only = 1'b1; op.ext = EXT_1000; end
      3'd2: begin op.code = 8'h30; op.nib_only = 1'b1; op.ext = EXT_1000; end
      3'd3: begin op.code = 8'h20; op.nib_only = 1'b1; op.ext = EXT_1000; end
      3'd4: begin op.code = 8'h28; op.ext = EXT_2000; end
      3'd5: begin op.code = 8'h0C; op.ext = EXT_2000; end
      3'd6: begin op.code = 8'h06; op.ext = EXT_2000; end
      default: begin op.code = LCD_CMD_CLEAR; op.ext = EXT_4000; op.last = 1'b1; end
    endcase
    return op;
  endfunction

endpackage

// ----- rtl/core/clbw_front.sv -----
// ----------------------------------------------------------------------------
// clbw_front
// Accepts requests and breaks them into byte/nibble ops for the op queue.
// ----------------------------------------------------------------------------
module clbw_front import clbw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic [5:0]        column,
  input  logic              row,
  input  logic [7:0]        char_code,
  input  logic signed [15:0] number,
  input  logic [7:0]        row0_base,
  input  logic [7:0]        row1_base,
  input  clbw_qstat_t       qstat,
  output logic              push,
  output clbw_op_t          push_op
);

  clbw_fstate_t    state, state_next;
  logic [2:0]      kind, kind_next;
  logic [5:0]      col, col_next;
  logic            rsel, rsel_next;
  logic [7:0]      ch, ch_next;
  logic [2:0]      idx, idx_next;
  logic [15:0]     mag, mag_next;
  logic [4:0][3:0] bcd, bcd_next;
  logic [4:0][3:0] adj;
  logic [3:0]      cnt, cnt_next;
  logic            started, started_next;
  logic [15:0]     num_u;
  clbw_op_t        cmd_op;
  logic [3:0]      dig;

  assign num_u    = $unsigned(number);
  assign in_ready = (state == F_IDLE);

  // add-3 correction ahead of each double-dabble shift
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  assign dig = bcd[idx];

  always_comb begin
    cmd_op.data     = 1'b0;
    cmd_op.nib_only = 1'b0;
    cmd_op.ext      = EXT_NONE;
    cmd_op.last     = 1'b1;
    cmd_op.code     = LCD_CMD_CLEAR;
    unique case (kind)
      REQ_INIT:   cmd_op = init_op(idx);
      REQ_CLEAR:  cmd_op.ext = EXT_4000;
      REQ_CURSOR: begin
        cmd_op.code = (rsel ? row1_base : row0_base) + {2'b00, col};
        cmd_op.ext  = EXT_2000;
      end
      REQ_CHAR: begin
        cmd_op.code = ch;
        cmd_op.data = 1'b1;
      end
      default: begin
        // integer zero
        cmd_op.code = CH_ZERO;
        cmd_op.data = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    col_next     = col;
    rsel_next    = rsel;
    ch_next      = ch;
    idx_next     = idx;
    mag_next     = mag;
    bcd_next     = bcd;
    cnt_next     = cnt;
    started_next = started;
    push         = 1'b0;
    push_op      = cmd_op;
    unique case (state)
      F_IDLE: begin
        if (in_valid) begin
          kind_next = req_type;
          col_next  = column;
          rsel_next = row;
          ch_next   = char_code;
          idx_next  = 3'd0;
          cnt_next  = 4'd0;
          bcd_next  = '0;
          mag_next  = num_u[15] ? (~num_u + 16'd1) : num_u;
          unique case (req_type) inside
            REQ_INIT, REQ_CLEAR, REQ_CURSOR, REQ_CHAR: state_next = F_CMD;
            REQ_INT: begin
              if (num_u == 16'd0) state_next = F_CMD;
              else if (num_u[15]) state_next = F_SIGN;
              else                state_next = F_CONV;
            end
            default: state_next = F_IDLE;
          endcase
        end
      end
      F_CMD: begin
        push = !qstat.full;
        if (push) begin
          if (cmd_op.last) state_next = F_IDLE;
          else             idx_next   = idx + 3'd1;
        end
      end
      F_SIGN: begin
        push_op.code     = CH_MINUS;
        push_op.data     = 1'b1;
        push_op.nib_only = 1'b0;
        push_op.ext      = EXT_NONE;
        push_op.last     = 1'b0;
        push = !qstat.full;
        if (push) state_next = F_CONV;
      end
      F_CONV: begin
        bcd_next = {adj[4][2:0], adj[3], adj[2], adj[1], adj[0], mag[15]};
        mag_next = {mag[14:0], 1'b0};
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd15) begin
          state_next   = F_DIGIT;
          idx_next     = 3'd4;
          started_next = 1'b0;
        end
      end
      F_DIGIT: begin
        push_op.code     = CH_ZERO | {4'h0, dig};
        push_op.data     = 1'b1;
        push_op.nib_only = 1'b0;
        push_op.ext      = EXT_NONE;
        push_op.last     = (idx == 3'd0);
        if (!started && dig == 4'd0 && idx != 3'd0) begin
          idx_next = idx - 3'd1;     // leading zero
        end else begin
          push = !qstat.full;
          if (push) begin
            started_next = 1'b1;
            if (idx == 3'd0) state_next = F_IDLE;
            else             idx_next   = idx - 3'd1;
          end
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    kind    <= kind_next;
    col     <= col_next;
    rsel    <= rsel_next;
    ch      <= ch_next;
    idx     <= idx_next;
    mag     <= mag_next;
    bcd     <= bcd_next;
    cnt     <= cnt_next;
    started <= started_next;
  end

endmodule

// ----- rtl/core/clbw_fifo.sv -----
// ----------------------------------------------------------------------------
// clbw_fifo
// Short op queue between the request front end and the write sequencer.
// ----------------------------------------------------------------------------
module clbw_fifo import clbw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  clbw_op_t    push_op,
  input  logic        pop,
  output clbw_op_t    pop_op,
  output clbw_qstat_t qstat
);

  clbw_op_t          q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign pop_op      = q[rd_ptr];
  assign qstat.count = count;
  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= push_op;
  end

endmodule

// ----- rtl/core/clbw_back.sv -----
// ----------------------------------------------------------------------------
// clbw_back
// Expands each queued op into strobe-high/strobe-low expander writes.
// ----------------------------------------------------------------------------
module clbw_back import clbw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  clbw_qstat_t qstat,
  input  clbw_op_t    pop_op,
  output logic        pop,
  input  clbw_masks_t masks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  expander_byte,
  output logic [12:0] wait_after_us,
  output logic        last
);

  clbw_op_t    cur;
  logic        cur_valid;
  logic [1:0]  phase;
  logic        slot_free, adv, final_nib, final_wr;
  logic [3:0]  nib;
  logic [7:0]  base_byte;
  logic [7:0]  wr_byte;
  logic [12:0] wr_wait;

  assign slot_free = !out_valid || out_ready;
  assign adv       = cur_valid && slot_free;
  assign final_nib = cur.nib_only || phase[1];
  assign final_wr  = final_nib && phase[0];
  assign pop       = !qstat.empty && (!cur_valid || (adv && final_wr));

  assign nib       = phase[1] ? cur.code[3:0] : cur.code[7:4];
  assign base_byte = {nib, 4'h0} | masks.backlight_mask | (cur.data ? masks.rs_mask : 8'h00);

  always_comb begin
    if (!phase[0]) begin
      wr_byte = base_byte | masks.enable_mask;
      wr_wait = WAIT_STROBE_HI;
    end else begin
      wr_byte = base_byte & ~masks.enable_mask;
      wr_wait = WAIT_STROBE_LO + (final_nib ? ext_us(cur.ext) : 13'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      phase     <= 2'd0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        phase     <= 2'd0;
      end else if (adv) begin
        if (final_wr) cur_valid <= 1'b0;
        phase <= phase + 2'd1;
      end
      if (adv)            out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= pop_op;
    if (adv) begin
      expander_byte <= wr_byte;
      wait_after_us <= wr_wait;
      last          <= cur.last && final_wr;
    end
  end

endmodule

// ----- rtl/core/char_lcd_i2c_backpack_writer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_i2c_backpack_writer
// Converts display requests into expander writes for a 4-bit character LCD.
// ----------------------------------------------------------------------------
// Each request (init, clear, set cursor, character, signed integer) becomes a
// run of expander bytes, one word on the out channel per write, each with the
// settle wait in microseconds to observe after it and last set on the final
// write. Every LCD byte goes out as high nibble then low nibble, each nibble as
// an enable-high write (1 us) and an enable-low write (50 us plus any command
// delay). The front end accepts a request, splits it into byte ops and drops
// them into a two-deep queue; the back end turns each op into writes at one
// word per cycle while out_ready is high and the queue holds ops. Request
// sizes: init is 24 writes, clear/cursor/char 4 writes, an integer 4 writes
// per sign or digit (up to 24). Integers also pass through a shift-and-add-3
// binary-to-decimal converter before the first digit can be queued, and
// leading zeros are then skipped one digit at a time; a sign byte drains in
// parallel with the conversion. in_ready rises again as soon as the front end
// has queued the last op, so the next request is taken while the back end is
// still emitting. Codes 5-7 produce no writes. Configuration (cfg_we/cfg_index/
// cfg_data) must be written only while idle; the block does not enforce this.
// Indexes beyond 4 are ignored.
// ----------------------------------------------------------------------------
module char_lcd_i2c_backpack_writer import clbw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           req_type,
  input  logic [5:0]           column,
  input  logic                 row,
  input  logic [7:0]           char_code,
  input  logic signed [15:0]   number,
  // expander write channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           expander_byte,
  output logic [12:0]          wait_after_us,
  output logic                 last
);

  // configuration registers
  clbw_masks_t masks;
  logic [7:0]  row0_base;
  logic [7:0]  row1_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks.rs_mask        <= 8'h01;
      masks.enable_mask    <= 8'h04;
      masks.backlight_mask <= 8'h08;
      row0_base            <= 8'h80;
      row1_base            <= 8'hC0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RS_MASK:        masks.rs_mask        <= cfg_data;
        CFG_ENABLE_MASK:    masks.enable_mask    <= cfg_data;
        CFG_BACKLIGHT_MASK: masks.backlight_mask <= cfg_data;
        CFG_ROW0_BASE:      row0_base            <= cfg_data;
        CFG_ROW1_BASE:      row1_base            <= cfg_data;
        default: ;  // unused index
      endcase
    end
  end

  // front end -> op queue -> write sequencer
  logic        push, pop;
  clbw_op_t    push_op, pop_op;
  clbw_qstat_t qstat;

  clbw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .column    (column),
    .row       (row),
    .char_code (char_code),
    .number    (number),
    .row0_base (row0_base),
    .row1_base (row1_base),
    .qstat     (qstat),
    .push      (push),
    .push_op   (push_op)
  );

  clbw_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .qstat   (qstat)
  );

  clbw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .pop_op        (pop_op),
    .pop           (pop),
    .masks         (masks),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .expander_byte (expander_byte),
    .wait_after_us (wait_after_us),
    .last          (last)
  );

  // queue occupancy never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("op queue overflow");

  // front end never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push while queue full");

  // final word of a request is always an enable-low write
  a_last_is_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (wait_after_us >= WAIT_STROBE_LO))
    else $error("last on enable-high write");

  // every wait is either the strobe time or a settle time
  a_wait_kinds: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (wait_after_us == WAIT_STROBE_HI || wait_after_us >= WAIT_STROBE_LO))
    else $error("bad settle wait");

endmodule

// ----- tb/char_lcd_i2c_backpack_writer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_i2c_backpack_writer_test
// Self-checking bench: display requests in, expander writes checked in order.
// ----------------------------------------------------------------------------
// Each request is predicted as it is presented: the expected run of expander
// words is built from local copies of the five mask/base registers and queued.
// A monitor pops one expectation per accepted output word and compares byte,
// settle wait and last. Directed requests cover reset values, mask extremes,
// overlapping masks, address wrap, integer corner values, unknown kinds and
// writes to unused register indexes; random phases reload all registers and
// mix request kinds, with random stalls on both channels except in the final
// phase.
// ----------------------------------------------------------------------------
module char_lcd_i2c_backpack_writer_test;
  import clbw_pkg::*;

  localparam int  TIMEOUT_NS    = 5_000_000;
  localparam int  SETTLE_CYCLES = 40;     // covers an integer conversion with no output
  localparam int  PHASE_ITEMS   = 50;
  localparam int  PHASE_COUNT   = 4;

  // Command bytes of the power-up sequence
  localparam logic [7:0] LCD_FUNC_8BIT  = 8'h30;
  localparam logic [7:0] LCD_FUNC_4BIT  = 8'h20;
  localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
  localparam logic [7:0] LCD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] RS_NONE        = 8'h00;

  // Extra settle time on the final strobe-low write of a command
  localparam logic [12:0] EXTRA_NONE    = 13'd0;
  localparam logic [12:0] EXTRA_POWERUP = 13'd5000;
  localparam logic [12:0] EXTRA_RESYNC  = 13'd1000;
  localparam logic [12:0] EXTRA_CMD     = 13'd2000;
  localparam logic [12:0] EXTRA_CLEAR   = 13'd4000;

  typedef struct packed {
    logic [7:0]  pattern;
    logic [12:0] wait_us;
    logic        last;
  } lcd_write_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           req_type;
  logic [5:0]           column;
  logic                 row;
  logic [7:0]           char_code;
  logic signed [15:0]   number;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           expander_byte;
  logic [12:0]          wait_after_us;
  logic                 last;

  // Local copy of the register file
  logic [7:0] rs_pattern;
  logic [7:0] strobe_pattern;
  logic [7:0] backlight_pattern;
  logic [7:0] row0_addr;
  logic [7:0] row1_addr;

  lcd_write_t expected_writes[$];
  int         mismatch_count;
  int         stall_left;
  bit         idle_enable;

  char_lcd_i2c_backpack_writer i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .column        (column),
    .row           (row),
    .char_code     (char_code),
    .number        (number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .expander_byte (expander_byte),
    .wait_after_us (wait_after_us),
    .last          (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One nibble: strobe-high write, then strobe-low write with the settle time.
  // The low write clears every strobe bit, even ones shared with other masks.
  function automatic void push_nibble(logic [7:0] nib, logic [7:0] rsel,
                                      logic [12:0] extra);
    logic [7:0] bits;
    lcd_write_t w;
    bits      = (nib & 8'hF0) | backlight_pattern | rsel;
    w.pattern = bits | strobe_pattern;
    w.wait_us = WAIT_STROBE_HI;
    w.last    = 1'b0;
    expected_writes.push_back(w);
    w.pattern = bits & ~strobe_pattern;
    w.wait_us = WAIT_STROBE_LO + extra;
    expected_writes.push_back(w);
  endfunction

  function automatic void push_lcd_byte(logic [7:0] code, logic [7:0] rsel,
                                        logic [12:0] extra);
    push_nibble(code & 8'hF0, rsel, EXTRA_NONE);
    push_nibble({code[3:0], 4'h0}, rsel, extra);
  endfunction

  function automatic void predict_request(logic [2:0] kind, logic [5:0] col,
                                          logic row_sel, logic [7:0] ch,
                                          logic signed [15:0] num);
    int         start_count;
    int         mag;
    int         ndig;
    logic [7:0] digit_chars[5];
    lcd_write_t tail;
    start_count = expected_writes.size();
    case (kind)
      REQ_INIT: begin
        push_nibble(LCD_FUNC_8BIT, RS_NONE, EXTRA_POWERUP);
        push_nibble(LCD_FUNC_8BIT, RS_NONE, EXTRA_RESYNC);
        push_nibble(LCD_FUNC_8BIT, RS_NONE, EXTRA_RESYNC);
        push_nibble(LCD_FUNC_4BIT, RS_NONE, EXTRA_RESYNC);
        push_lcd_byte(LCD_FUNC_SET, RS_NONE, EXTRA_CMD);
        push_lcd_byte(LCD_DISPLAY_ON, RS_NONE, EXTRA_CMD);
        push_lcd_byte(LCD_ENTRY_MODE, RS_NONE, EXTRA_CMD);
        push_lcd_byte(LCD_CMD_CLEAR, RS_NONE, EXTRA_CLEAR);
      end
      REQ_CLEAR:  push_lcd_byte(LCD_CMD_CLEAR, RS_NONE, EXTRA_CLEAR);
      // address wraps at 8 bits through the argument width
      REQ_CURSOR: push_lcd_byte((row_sel ? row1_addr : row0_addr) + {2'b00, col},
                                RS_NONE, EXTRA_CMD);
      REQ_CHAR:   push_lcd_byte(ch, rs_pattern, EXTRA_NONE);
      REQ_INT: begin
        if (num == 0) begin
          push_lcd_byte(CH_ZERO, rs_pattern, EXTRA_NONE);
        end else begin
          mag = int'(num);
          if (mag < 0) begin
            push_lcd_byte(CH_MINUS, rs_pattern, EXTRA_NONE);
            mag = -mag;           // most negative value gives 32768
          end
          ndig = 0;
          while (mag > 0) begin
            digit_chars[ndig] = CH_ZERO + 8'(mag % 10);
            ndig++;
            mag = mag / 10;
          end
          for (int i = ndig - 1; i >= 0; i--) begin
            push_lcd_byte(digit_chars[i], rs_pattern, EXTRA_NONE);
          end
        end
      end
      default: ;                  // unknown kinds produce nothing
    endcase
    if (expected_writes.size() > start_count) begin
      tail      = expected_writes.pop_back();
      tail.last = 1'b1;
      expected_writes.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // The write strobe is cleared before the task returns, which keeps a single NBA on cfg_we per time step.
  task automatic write_reg(int idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= val;
    @(posedge clk);
    case (CFG_IDX_W'(idx))
      CFG_RS_MASK:        rs_pattern        = val;
      CFG_ENABLE_MASK:    strobe_pattern    = val;
      CFG_BACKLIGHT_MASK: backlight_pattern = val;
      CFG_ROW0_BASE:      row0_addr         = val;
      CFG_ROW1_BASE:      row1_addr         = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(logic [7:0] rs_v, logic [7:0] en_v, logic [7:0] bl_v,
                             logic [7:0] r0_v, logic [7:0] r1_v);
    write_reg(int'(CFG_RS_MASK), rs_v);
    write_reg(int'(CFG_ENABLE_MASK), en_v);
    write_reg(int'(CFG_BACKLIGHT_MASK), bl_v);
    write_reg(int'(CFG_ROW0_BASE), r0_v);
    write_reg(int'(CFG_ROW1_BASE), r1_v);
  endtask

  // Present one request; returns right after the edge that took it.
  task automatic issue_request(logic [2:0] kind, logic [5:0] col, logic row_sel,
                               logic [7:0] ch, logic signed [15:0] num);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= kind;
    column    <= col;
    row       <= row_sel;
    char_code <= ch;
    number    <= num;
    predict_request(kind, col, row_sel, ch, num);
    do @(posedge clk); while (!in_ready);
  endtask

  // Block idle: every expected word seen, plus time for a silent request.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_reg_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Output monitor and ready stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lcd_write_t want;
    logic       ready_next;
    if (!rst && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word byte=%02h wait=%0d last=%0b",
                 $time, expander_byte, wait_after_us, last);
      end else begin
        want = expected_writes.pop_front();
        if (expander_byte !== want.pattern) begin
          mismatch_count++;
          $display("%0t: expander_byte expected %02h actual %02h",
                   $time, want.pattern, expander_byte);
        end
        if (wait_after_us !== want.wait_us) begin
          mismatch_count++;
          $display("%0t: wait_after_us expected %0d actual %0d",
                   $time, want.wait_us, wait_after_us);
        end
        if (last !== want.last) begin
          mismatch_count++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, last);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      ready_next = 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      ready_next = 1'b0;
    end else begin
      ready_next = 1'b1;
    end
    out_ready <= ready_next;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: every kind, integer corners, unknown kinds.
  task automatic test_reset_defaults();
    issue_request(REQ_INIT, 6'd0, 1'b0, 8'h00, 16'sd0);
    issue_request(REQ_CLEAR, 6'd0, 1'b0, 8'h00, 16'sd0);
    issue_request(REQ_CURSOR, 6'd0, 1'b0, 8'h00, 16'sd0);
    issue_request(REQ_CURSOR, 6'd63, 1'b1, 8'hFF, -16'sd1);
    issue_request(REQ_CHAR, 6'd0, 1'b0, 8'h00, 16'sd0);
    issue_request(REQ_CHAR, 6'd63, 1'b1, 8'hFF, 16'sd0);
    issue_request(REQ_INT, 6'd0, 1'b0, 8'h00, 16'sd0);
    issue_request(REQ_INT, 6'd0, 1'b0, 8'h00, 16'sd1);
    issue_request(REQ_INT, 6'd0, 1'b0, 8'h00, -16'sd1);
    issue_request(REQ_INT, 6'd0, 1'b0, 8'h00, 16'sd10);
    issue_request(REQ_INT, 6'd0, 1'b0, 8'h00, 16'sd32767);
    issue_request(REQ_INT, 6'd0, 1'b0, 8'h00, -16'sd32768);
    for (int k = REQ_INT + 1; k < 2 ** $bits(req_type); k++) begin
      issue_request(3'(k), 6'd63, 1'b1, 8'hFF, -16'sd1);
    end
    wait_idle();
  endtask

  // All-ones and all-zeros masks, overlapping masks, address wrap.
  task automatic test_mask_extremes();
    load_config(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    issue_request(REQ_INIT, 6'd0, 1'b0, 8'h00, 16'sd0);
    issue_request(REQ_CHAR, 6'd0, 1'b0, 8'hA5, 16'sd0);
    issue_request(REQ_CURSOR, 6'd63, 1'b1, 8'h00, 16'sd0);   // 0xFF + 63 wraps
    issue_request(REQ_CURSOR, 6'd5, 1'b0, 8'h00, 16'sd0);
    wait_idle();
    load_config(8'h00, 8'h00, 8'h00, 8'hC1, 8'h00);
    issue_request(REQ_CHAR, 6'd0, 1'b0, 8'h5A, 16'sd0);
    issue_request(REQ_INT, 6'd0, 1'b0, 8'h00, -16'sd7);
    wait_idle();
    // strobe shares bits with register select and backlight
    load_config(8'h06, 8'h0C, 8'h08, 8'h80, 8'hC0);
    issue_request(REQ_CHAR, 6'd0, 1'b0, 8'h41, 16'sd0);
    wait_idle();
  endtask

  // Writes past the last register must leave the register file alone.
  task automatic test_unused_index();
    for (int idx = CFG_ROW1_BASE + 1; idx < 2 ** CFG_IDX_W; idx++) begin
      write_reg(idx, 8'h5A);
    end
    issue_request(REQ_CHAR, 6'd0, 1'b0, 8'h33, 16'sd0);
    issue_request(REQ_CURSOR, 6'd17, 1'b1, 8'h00, 16'sd0);
    wait_idle();
  endtask

  // Random register settings per phase, weighted request mix.
  task automatic test_random_traffic();
    int                 r;
    logic [2:0]         kind;
    logic signed [15:0] num;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      idle_enable = (phase != PHASE_COUNT - 1);
      load_config(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                  pick_reg_value(), pick_reg_value());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4)       kind = REQ_INIT;
        else if (r < 12) kind = REQ_CLEAR;
        else if (r < 30) kind = REQ_CURSOR;
        else if (r < 58) kind = REQ_CHAR;
        else if (r < 94) kind = REQ_INT;
        else             kind = 3'($urandom_range(REQ_INT + 1, 2 ** $bits(req_type) - 1));
        r = $urandom_range(0, 9);
        if (r < 5)       num = 16'($urandom_range(0, 65535));
        else if (r < 9)  num = 16'(int'($urandom_range(0, 198)) - 99);
        else             num = r[0] ? -16'sd32768 : 16'sd0;
        issue_request(kind, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), num);
      end
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count    = 0;
    stall_left        = 0;
    idle_enable       = 1'b1;
    rs_pattern        = 8'h01;
    strobe_pattern    = 8'h04;
    backlight_pattern = 8'h08;
    row0_addr         = 8'h80;
    row1_addr         = 8'hC0;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    req_type  <= REQ_INIT;
    column    <= '0;
    row       <= 1'b0;
    char_code <= '0;
    number    <= '0;
    out_ready <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_mask_extremes();
    test_unused_index();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
